// ===== rtl/cse_pkg.sv =====
package cse_pkg;

    // Width of the character budget register and its value after reset.
    localparam int BUDGET_W = 16;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd256;

    // ASCII codes used in the CIGAR text.
    localparam logic [6:0] CH_NONE = 7'h00;
    localparam logic [6:0] CH_0    = 7'h30;
    localparam logic [6:0] CH_M    = 7'h4D;
    localparam logic [6:0] CH_I    = 7'h49;
    localparam logic [6:0] CH_D    = 7'h44;

    // States of the back end sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_COUNT,
        ST_DIGIT,
        ST_LETTER
    } back_state_t;

    // Which of the three numbers of an item is being written.
    typedef enum logic [1:0] {
        PH_X,
        PH_Y,
        PH_LEN
    } phase_t;

    // Classification that the front end attaches to every queued item.
    typedef struct packed {
        logic new_align;
        logic x_gap_ok;
        logic y_gap_ok;
    } item_flags_t;

    // One result item.
    typedef struct packed {
        logic [6:0] char_code;
        logic       is_last;
        logic       budget_hit;
    } result_t;

    // Power of ten, evaluated at elaboration only.
    function automatic logic [63:0] pow10(input int k);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < 20; i++) begin
            if (i < k) begin
                r = r * 64'd10;
            end
        end
        return r;
    endfunction

    // Decimal digits needed for the largest value of a given bit width.
    function automatic int max_digits(input int bits);
        logic [63:0] v;
        int          n;
        v = (64'd1 << bits) - 64'd1;
        n = 1;
        for (int i = 0; i < 20; i++) begin
            if (v >= 64'd10) begin
                v = v / 64'd10;
                n++;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/cigar_string_encoder.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------------
// input    | in        | push / full          | kind, x_start, y_start, block_len
// result   | out       | pop / empty          | char_code, is_last, budget_hit
// config   | in        | cfg_valid / cfg_ready| cfg_data (character budget)
//
// In the back end the digit loop writes one character per cycle while the result
// queue has room. The front end takes a new item each cycle while the two-entry
// item queue has room. Reset clears the previous block, the budget count and the
// stop flag, and loads a budget of 256. A full result queue stalls the back end
// at the next character; the front end keeps accepting.
module cigar_string_encoder
    import cse_pkg::*;
#(
    parameter int POS_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                kind,
    input  logic [31:0]         x_start,
    input  logic [31:0]         y_start,
    input  logic [31:0]         block_len,
    output logic                empty,
    input  logic                pop,
    output logic [6:0]          char_code,
    output logic                is_last,
    output logic                budget_hit,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BUDGET_W-1:0] cfg_data
);

    localparam int ITEM_W = $bits(item_flags_t) + 3 * POS_BITS;
    localparam int RES_W  = $bits(result_t);

    logic                fq_wr;
    item_flags_t         fq_flags;
    logic [POS_BITS-1:0] fq_x_gap;
    logic [POS_BITS-1:0] fq_y_gap;
    logic [POS_BITS-1:0] fq_len;
    logic [ITEM_W-1:0]   bq_data;
    logic                bq_empty;
    logic                bq_pop;
    logic                rq_full;
    logic                rq_push;
    result_t             rq_wdata;
    result_t             rq_rdata;

    assign cfg_ready = 1'b1;

    // Front end: classify items and compute gaps.
    cse_front #(
        .POS_BITS(POS_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .q_full (full),
        .kind   (kind),
        .x_pos  (POS_BITS'(x_start)),
        .y_pos  (POS_BITS'(y_start)),
        .len    (POS_BITS'(block_len)),
        .q_wr   (fq_wr),
        .q_flags(fq_flags),
        .q_x_gap(fq_x_gap),
        .q_y_gap(fq_y_gap),
        .q_len  (fq_len)
    );

    // Item queue between the front and back ends.
    cse_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(2)
    ) u_item_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fq_wr),
        .wr_data({fq_flags, fq_x_gap, fq_y_gap, fq_len}),
        .full   (full),
        .rd_en  (bq_pop),
        .rd_data(bq_data),
        .empty  (bq_empty)
    );

    // Back end: budget tracking and decimal output.
    cse_back #(
        .POS_BITS(POS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (bq_empty),
        .q_pop    (bq_pop),
        .q_flags  (item_flags_t'(bq_data[ITEM_W-1 -: $bits(item_flags_t)])),
        .q_x_gap  (bq_data[3*POS_BITS-1 -: POS_BITS]),
        .q_y_gap  (bq_data[2*POS_BITS-1 -: POS_BITS]),
        .q_len    (bq_data[POS_BITS-1:0]),
        .out_full (rq_full),
        .out_push (rq_push),
        .out_res  (rq_wdata),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data)
    );

    // Result queue toward the output port.
    cse_fifo #(
        .WIDTH(RES_W),
        .DEPTH(4)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (rq_push),
        .wr_data(rq_wdata),
        .full   (rq_full),
        .rd_en  (pop),
        .rd_data(rq_rdata),
        .empty  (empty)
    );

    assign char_code  = rq_rdata.char_code;
    assign is_last    = rq_rdata.is_last;
    assign budget_hit = rq_rdata.budget_hit;

endmodule

// ===== rtl/cse_fifo.sv =====
module cse_fifo
    import cse_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    // DEPTH is a power of two, so the pointers wrap on their own.
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/cse_front.sv =====
module cse_front
    import cse_pkg::*;
#(
    parameter int POS_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                q_full,
    input  logic                kind,
    input  logic [POS_BITS-1:0] x_pos,
    input  logic [POS_BITS-1:0] y_pos,
    input  logic [POS_BITS-1:0] len,
    output logic                q_wr,
    output item_flags_t         q_flags,
    output logic [POS_BITS-1:0] q_x_gap,
    output logic [POS_BITS-1:0] q_y_gap,
    output logic [POS_BITS-1:0] q_len
);

    // End positions of the previous block carry one extra bit.
    logic [POS_BITS:0] prev_x_reg, prev_x_next;
    logic [POS_BITS:0] prev_y_reg, prev_y_next;
    logic              have_prev_reg, have_prev_next;
    logic              have;

    assign q_wr = push && !q_full;
    assign have = kind && have_prev_reg;

    // Classify the item: a gap is written only when strictly positive.
    // While an alignment is stopped the stored ends do not matter, since only
    // a new alignment clears the stop and that also drops the previous block.
    always_comb
    begin
        q_flags.new_align = !kind;
        q_flags.x_gap_ok  = have && (prev_x_reg < {1'b0, x_pos});
        q_flags.y_gap_ok  = have && (prev_y_reg < {1'b0, y_pos});
        q_x_gap           = x_pos - prev_x_reg[POS_BITS-1:0];
        q_y_gap           = y_pos - prev_y_reg[POS_BITS-1:0];
        q_len             = len;

        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        if (q_wr)
        begin
            prev_x_next    = {1'b0, x_pos} + {1'b0, len};
            prev_y_next    = {1'b0, y_pos} + {1'b0, len};
            have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

// ===== rtl/cse_back.sv =====
module cse_back
    import cse_pkg::*;
#(
    parameter int POS_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                q_pop,
    input  item_flags_t         q_flags,
    input  logic [POS_BITS-1:0] q_x_gap,
    input  logic [POS_BITS-1:0] q_y_gap,
    input  logic [POS_BITS-1:0] q_len,
    input  logic                out_full,
    output logic                out_push,
    output result_t             out_res,
    input  logic                cfg_valid,
    input  logic [BUDGET_W-1:0] cfg_data
);

    localparam int MAX_DIG = max_digits(POS_BITS);
    localparam int K_W     = $clog2(MAX_DIG);
    localparam int DIG_W   = $clog2(MAX_DIG + 1);
    localparam int CMP_W   = POS_BITS + 4;

    // Constant table of d * 10^k for every digit place k and digit d.
    logic [CMP_W-1:0] mult_tab [MAX_DIG][1:9];

    for (genvar gi = 0; gi < MAX_DIG; gi++)
    begin : g_place
        for (genvar gd = 1; gd <= 9; gd++)
        begin : g_digit
            assign mult_tab[gi][gd] = CMP_W'(pow10(gi) * 64'(gd));
        end
    end

    back_state_t         state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [BUDGET_W-1:0] chars_reg, chars_next;
    logic                stopped_reg, stopped_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [K_W-1:0]      k_reg, k_next;

    item_flags_t         flags_reg, flags_next;
    logic [POS_BITS-1:0] xg_reg, xg_next;
    logic [POS_BITS-1:0] yg_reg, yg_next;
    logic [POS_BITS-1:0] len_reg, len_next;
    logic [POS_BITS-1:0] val_reg, val_next;
    logic [6:0]          letter_reg, letter_next;

    logic [CMP_W-1:0]    val_ext;
    logic [DIG_W-1:0]    ndig;
    logic [3:0]          dig;
    logic [CMP_W-1:0]    sub;
    logic [BUDGET_W-1:0] rem;
    logic                no_fit;
    logic                budget_end;

    assign val_ext = {4'b0, val_reg};

    // Digit count: one more than the number of powers of ten from 10 up not above the value.
    always_comb
    begin
        ndig = DIG_W'(1);
        for (int i = 1; i < MAX_DIG; i++)
        begin
            if (val_ext >= mult_tab[i][1])
            begin
                ndig = ndig + DIG_W'(1);
            end
        end
    end

    // Leading digit at place k: the largest multiple of 10^k not above the value.
    always_comb
    begin
        dig = 4'd0;
        sub = '0;
        for (int d = 1; d <= 9; d++)
        begin
            if (val_ext >= mult_tab[k_reg][d])
            begin
                dig = 4'(d);
                sub = mult_tab[k_reg][d];
            end
        end
    end

    // Room left in the budget and the two stop conditions.
    assign rem        = (chars_reg >= budget_reg) ? '0 : (budget_reg - chars_reg);
    assign no_fit     = (BUDGET_W'(ndig) >= rem);
    assign budget_end = (({1'b0, chars_reg} + 17'd2) == {1'b0, budget_reg});

    // Sequencer: take an item, then write each number digit by digit.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        chars_next   = chars_reg;
        stopped_next = stopped_reg;
        budget_next  = budget_reg;
        k_next       = k_reg;
        flags_next   = flags_reg;
        xg_next      = xg_reg;
        yg_next      = yg_reg;
        len_next     = len_reg;
        val_next     = val_reg;
        letter_next  = letter_reg;
        q_pop        = 1'b0;
        out_push     = 1'b0;
        out_res      = '{char_code: CH_NONE, is_last: 1'b0, budget_hit: 1'b0};

        if (cfg_valid)
        begin
            budget_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    flags_next = q_flags;
                    xg_next    = q_x_gap;
                    yg_next    = q_y_gap;
                    len_next   = q_len;
                    phase_next = PH_X;
                    if (q_flags.new_align)
                    begin
                        chars_next   = '0;
                        stopped_next = 1'b0;
                        state_next   = ST_NEXT;
                    end
                    else if (!stopped_reg)
                    begin
                        state_next = ST_NEXT;
                    end
                end
            end

            ST_NEXT:
            begin
                unique case (phase_reg)
                    PH_X:
                    begin
                        if (flags_reg.x_gap_ok)
                        begin
                            val_next    = xg_reg;
                            letter_next = CH_I;
                            state_next  = ST_COUNT;
                        end
                        else
                        begin
                            phase_next = PH_Y;
                        end
                    end
                    PH_Y:
                    begin
                        if (flags_reg.y_gap_ok)
                        begin
                            val_next    = yg_reg;
                            letter_next = CH_D;
                            state_next  = ST_COUNT;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    default:
                    begin
                        val_next    = len_reg;
                        letter_next = CH_M;
                        state_next  = ST_COUNT;
                    end
                endcase
            end

            ST_COUNT:
            begin
                if (no_fit)
                begin
                    // The number does not fit: flag the stop and drop the rest.
                    if (!out_full)
                    begin
                        out_push     = 1'b1;
                        out_res      = '{char_code: CH_NONE, is_last: 1'b1,
                                         budget_hit: 1'b1};
                        stopped_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    k_next     = K_W'(ndig - DIG_W'(1));
                    state_next = ST_DIGIT;
                end
            end

            ST_DIGIT:
            begin
                if (!out_full)
                begin
                    out_push           = 1'b1;
                    out_res.char_code  = CH_0 + 7'(dig);
                    chars_next         = chars_reg + BUDGET_W'(1);
                    val_next           = POS_BITS'(val_ext - sub);
                    if (k_reg == '0)
                    begin
                        if (budget_end)
                        begin
                            // Budget reached: the letter is left out.
                            out_res.is_last    = 1'b1;
                            out_res.budget_hit = 1'b1;
                            stopped_next       = 1'b1;
                            state_next         = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_LETTER;
                        end
                    end
                    else
                    begin
                        k_next = k_reg - K_W'(1);
                    end
                end
            end

            ST_LETTER:
            begin
                if (!out_full)
                begin
                    out_push          = 1'b1;
                    out_res.char_code = letter_reg;
                    out_res.is_last   = (phase_reg == PH_LEN);
                    chars_next        = chars_reg + BUDGET_W'(1);
                    if (phase_reg == PH_LEN)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_t'(phase_reg + 2'd1);
                        state_next = ST_NEXT;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_X;
            chars_reg   <= '0;
            stopped_reg <= 1'b0;
            budget_reg  <= BUDGET_RESET;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            chars_reg   <= chars_next;
            stopped_reg <= stopped_next;
            budget_reg  <= budget_next;
            k_reg       <= k_next;
        end
    end

    // Item payload and working value.
    always_ff @(posedge clk)
    begin
        flags_reg  <= flags_next;
        xg_reg     <= xg_next;
        yg_reg     <= yg_next;
        len_reg    <= len_next;
        val_reg    <= val_next;
        letter_reg <= letter_next;
    end

endmodule

// ===== rtl/cse_checker.sv =====
module cse_checker
    import cse_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [6:0] char_code,
    input logic       is_last,
    input logic       budget_hit
);

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(char_code) && $stable(is_last)
            && $stable(budget_hit))
    else $error("result changed while waiting");

    // A flag-only result always marks a budget stop and ends its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (char_code == CH_NONE) |-> budget_hit && is_last)
    else $error("flag-only result without stop");

    // A budget stop is always the last character of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && budget_hit |-> is_last)
    else $error("budget stop not last");

    // A gap letter (I or D) never carries the budget flag and never ends an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (char_code == CH_I || char_code == CH_D) |-> !budget_hit && !is_last)
    else $error("gap letter flagged or last");

endmodule

bind cigar_string_encoder cse_checker u_cse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .is_last   (is_last),
    .budget_hit(budget_hit)
);

// ===== verif/testbench.sv =====
module testbench;
    import cse_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 45;

    // Directed rows either send a block or load a new character budget.
    typedef enum logic {
        ROW_BLOCK,
        ROW_BUDGET
    } row_op_t;

    // A budget row carries the new budget in the len field.
    typedef struct packed {
        row_op_t     op;
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] len;
        logic        typed;
        logic        hit;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    logic                kind;
    logic [31:0]         x_start;
    logic [31:0]         y_start;
    logic [31:0]         block_len;
    logic                empty;
    logic                pop;
    logic [6:0]          char_code;
    logic                is_last;
    logic                budget_hit;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BUDGET_W-1:0] cfg_data;

    // Mirror of the encoder state.
    logic [BUDGET_W-1:0] budget;
    logic [32:0]         prev_x_end;
    logic [32:0]         prev_y_end;
    logic                have_prev;
    int                  chars_used;
    logic                stopped;

    // Characters of the block being predicted, and all characters still owed.
    result_t             block_chars[$];
    result_t             pending_chars[$];
    result_t             want;

    row_t                rows[$];
    string               row_text[$];

    bit                  calm;
    bit                  hold_off_req;
    int                  errors;
    int                  cycle_count;
    int                  n_blocks;
    int                  n_chars;
    int                  n_stops;
    int                  n_budgets;

    cigar_string_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .x_start    (x_start),
        .y_start    (y_start),
        .block_len  (block_len),
        .empty      (empty),
        .pop        (pop),
        .char_code  (char_code),
        .is_last    (is_last),
        .budget_hit (budget_hit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Writes one number in decimal and then its letter, within the budget.
    // Returns 0 when the text of this alignment stops here.
    function automatic bit put_number(input logic [63:0] val, input logic [6:0] letter);
        logic [6:0] digits[$];
        result_t    r;
        int         room;
        do
        begin
            digits.push_front(CH_0 + 7'(val % 64'd10));
            val = val / 64'd10;
        end
        while (val != 64'd0);
        room = (chars_used >= int'(budget)) ? 0 : int'(budget) - chars_used;
        // A number that does not fit leaves only a stop flag.
        if (digits.size() >= room)
        begin
            stopped = 1'b1;
            r.char_code = CH_NONE;
            r.is_last = 1'b0;
            r.budget_hit = 1'b1;
            block_chars.push_back(r);
            return 1'b0;
        end
        foreach (digits[i])
        begin
            r.char_code = digits[i];
            r.is_last = 1'b0;
            r.budget_hit = 1'b0;
            block_chars.push_back(r);
        end
        chars_used += digits.size();
        // The budget is used up by the digits: the letter is dropped.
        if (chars_used + 1 == int'(budget))
        begin
            stopped = 1'b1;
            block_chars[$].budget_hit = 1'b1;
            return 1'b0;
        end
        r.char_code = letter;
        block_chars.push_back(r);
        chars_used = (chars_used + 1) & 16'hFFFF;
        return 1'b1;
    endfunction

    // Predicts the characters of one block and advances the mirrored state.
    function automatic void encode_block(input logic k, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] len);
        logic go;
        block_chars.delete();
        if (!k)
        begin
            have_prev = 1'b0;
            chars_used = 0;
            stopped = 1'b0;
        end
        if (stopped)
        begin
            return;
        end
        go = 1'b1;
        if (have_prev)
        begin
            if (prev_x_end < {1'b0, x})
            begin
                go = put_number(64'({1'b0, x} - prev_x_end), CH_I);
            end
            if (go && prev_y_end < {1'b0, y})
            begin
                go = put_number(64'({1'b0, y} - prev_y_end), CH_D);
            end
        end
        if (go)
        begin
            void'(put_number(64'(len), CH_M));
        end
        prev_x_end = {1'b0, x} + {1'b0, len};
        prev_y_end = {1'b0, y} + {1'b0, len};
        have_prev = 1'b1;
        if (block_chars.size() != 0)
        begin
            block_chars[$].is_last = 1'b1;
        end
    endfunction

    function automatic void add_row(input row_op_t op, input logic k, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] len,
                                    input logic typed, input string text, input logic hit);
        row_t r;
        r.op = op;
        r.kind = k;
        r.x = x;
        r.y = y;
        r.len = len;
        r.typed = typed;
        r.hit = hit;
        rows.push_back(r);
        row_text.push_back(text);
    endfunction

    // Offers one block until it is taken; the prediction is queued unless
    // the caller supplies its own expectation.
    task automatic send_block(input logic k, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] len, input bit keep);
        push <= 1'b1;
        kind <= k;
        x_start <= x;
        y_start <= y;
        block_len <= len;
        do
        begin
            @(posedge clk);
        end
        while (full);
        encode_block(k, x, y, len);
        n_blocks++;
        if (keep)
        begin
            foreach (block_chars[i])
            begin
                pending_chars.push_back(block_chars[i]);
            end
        end
    endtask

    // Random gap on the input side, at a rate set per phase.
    task automatic sender_pause(input int odds);
        if (!calm && odds != 0 && $urandom_range(1, odds) == 1)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Waits until every owed character is out and the block has gone quiet.
    task automatic settle();
        push <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(input logic [BUDGET_W-1:0] b);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= b;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        budget = b;
        n_budgets++;
    endtask

    // Receiver: random stalls, one long hold on request, none at the end.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Every character taken from the block is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected item: char_code %0h is_last %0b budget_hit %0b",
                       char_code, is_last, budget_hit);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                n_chars++;
                if (budget_hit)
                begin
                    n_stops++;
                end
                if (char_code !== want.char_code)
                begin
                    $error("char_code: expected %0h, actual %0h", want.char_code, char_code);
                    errors++;
                end
                if (is_last !== want.is_last)
                begin
                    $error("is_last: expected %0b, actual %0b", want.is_last, is_last);
                    errors++;
                end
                if (budget_hit !== want.budget_hit)
                begin
                    $error("budget_hit: expected %0b, actual %0b", want.budget_hit, budget_hit);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        string          text;
        result_t        r;
        logic           k;
        logic [31:0]    bx;
        logic [31:0]    by;
        logic [31:0]    bl;
        logic [31:0]    cur_x;
        logic [31:0]    cur_y;
        int             sel;
        int             odds;
        logic [15:0]    b;

        rst_n = 1'b0;
        push = 1'b0;
        kind = 1'b0;
        x_start = '0;
        y_start = '0;
        block_len = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        budget = BUDGET_RESET;
        prev_x_end = '0;
        prev_y_end = '0;
        have_prev = 1'b0;
        chars_used = 0;
        stopped = 1'b0;
        cur_x = '0;
        cur_y = '0;

        // Directed rows. Next block right after reset has no previous block.
        add_row(ROW_BLOCK, 1'b1, 32'd100, 32'd200, 32'd0, 1'b1, "0M", 1'b0);
        add_row(ROW_BLOCK, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1, "0M", 1'b0);
        add_row(ROW_BLOCK, 1'b1, 32'd10, 32'd5, 32'd7, 1'b1, "10I5D7M", 1'b0);
        // Overlap on x and no gap on y: only the length is written.
        add_row(ROW_BLOCK, 1'b1, 32'd3, 32'd12, 32'd1, 1'b1, "1M", 1'b0);
        add_row(ROW_BLOCK, 1'b0, '1, '1, '1, 1'b1, "4294967295M", 1'b0);
        add_row(ROW_BLOCK, 1'b1, 32'd0, 32'd0, 32'd3, 1'b0, "", 1'b0);
        add_row(ROW_BLOCK, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1, "0M", 1'b0);
        // Largest gaps and length: the longest text one block can produce.
        add_row(ROW_BLOCK, 1'b1, '1, '1, '1, 1'b1,
                "4294967295I4294967295D4294967295M", 1'b0);
        // Budget lowered in the middle of an alignment: the next number fails.
        add_row(ROW_BUDGET, 1'b0, '0, '0, 32'd6, 1'b0, "", 1'b0);
        add_row(ROW_BLOCK, 1'b1, 32'd0, 32'd0, 32'd5, 1'b1, "", 1'b1);
        add_row(ROW_BLOCK, 1'b1, 32'd0, 32'd0, 32'd5, 1'b1, "", 1'b0);
        // Budget reached right after the digits: the letter is dropped.
        add_row(ROW_BLOCK, 1'b0, 32'd0, 32'd0, 32'd123, 1'b1, "123M", 1'b0);
        add_row(ROW_BLOCK, 1'b1, 32'd123, 32'd123, 32'd7, 1'b1, "7", 1'b1);
        add_row(ROW_BLOCK, 1'b1, 32'd500, 32'd0, 32'd1, 1'b1, "", 1'b0);
        // Budget of 2: one digit ends it, two digits never fit.
        add_row(ROW_BUDGET, 1'b0, '0, '0, 32'd2, 1'b0, "", 1'b0);
        add_row(ROW_BLOCK, 1'b0, 32'd0, 32'd0, 32'd5, 1'b1, "5", 1'b1);
        add_row(ROW_BLOCK, 1'b0, 32'd0, 32'd0, 32'd12, 1'b1, "", 1'b1);
        add_row(ROW_BUDGET, 1'b0, '0, '0, 32'd65535, 1'b0, "", 1'b0);
        add_row(ROW_BLOCK, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_AAAA, 1'b0, "", 1'b0);
        add_row(ROW_BLOCK, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_5555, 1'b0, "", 1'b0);
        add_row(ROW_BLOCK, 1'b1, 32'hFFFF_FFF0, 32'h0000_0009, 32'd9, 1'b0, "", 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].op == ROW_BUDGET)
            begin
                write_budget(rows[i].len[15:0]);
            end
            else
            begin
                send_block(rows[i].kind, rows[i].x, rows[i].y, rows[i].len, !rows[i].typed);
                if (rows[i].typed)
                begin
                    text = row_text[i];
                    if (text.len() == 0 && rows[i].hit)
                    begin
                        r.char_code = CH_NONE;
                        r.is_last = 1'b1;
                        r.budget_hit = 1'b1;
                        pending_chars.push_back(r);
                    end
                    for (int j = 0; j < text.len(); j++)
                    begin
                        r.char_code = 7'(text[j]);
                        r.is_last = (j == text.len() - 1);
                        r.budget_hit = rows[i].hit && r.is_last;
                        pending_chars.push_back(r);
                    end
                end
                sender_pause(4);
            end
        end

        // Random phases, each under its own budget; the last one runs without gaps.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: b = 16'($urandom_range(8, 60));
                1: b = 16'd2;
                2: b = 16'd65535;
                3: b = 16'd3;
                4: b = 16'($urandom_range(2, 65535));
                5: b = 16'd24;
                6: b = BUDGET_RESET;
                default: b = 16'($urandom_range(12, 90));
            endcase
            write_budget(b);
            odds = (p % 3 == 2) ? 0 : $urandom_range(2, 8);
            if (p == PHASES - 1)
            begin
                calm = 1'b1;
            end

            // Receiver holds off while blocks keep coming, so the input backs up.
            if (p == 6)
            begin
                hold_off_req = 1'b1;
                repeat (40)
                begin
                    send_block(1'b0, $urandom, $urandom, $urandom, 1'b1);
                end
            end

            repeat (PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 10)
                begin
                    // Noise: any field value, any kind.
                    k = 1'($urandom_range(0, 1));
                    bx = $urandom;
                    by = $urandom;
                end
                else if (sel < 24)
                begin
                    k = 1'b0;
                    bx = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 10000)) : $urandom;
                    by = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 10000)) : $urandom;
                end
                else
                begin
                    k = 1'b1;
                    sel = $urandom_range(0, 99);
                    bx = (sel < 45) ? cur_x :
                         (sel < 80) ? cur_x + 32'($urandom_range(1, 300)) :
                         (sel < 90) ? cur_x + 32'($urandom_range(0, 1000000)) :
                                      cur_x - 32'($urandom_range(1, 50));
                    sel = $urandom_range(0, 99);
                    by = (sel < 45) ? cur_y :
                         (sel < 80) ? cur_y + 32'($urandom_range(1, 300)) :
                         (sel < 90) ? cur_y + 32'($urandom_range(0, 1000000)) :
                                      cur_y - 32'($urandom_range(1, 50));
                end
                sel = $urandom_range(0, 99);
                bl = (sel < 55) ? 32'($urandom_range(1, 99)) :
                     (sel < 80) ? 32'($urandom_range(0, 99999)) :
                     (sel < 88) ? 32'd0 : $urandom;
                cur_x = bx + bl;
                cur_y = by + bl;
                send_block(k, bx, by, bl, 1'b1);
                sender_pause(odds);
            end
        end

        settle();
        if (pending_chars.size() != 0)
        begin
            $error("%0d items never came out", pending_chars.size());
            errors++;
        end
        $display("Sent %0d blocks under %0d budget settings, including a long receiver hold.",
                 n_blocks, n_budgets);
        $display("Checked %0d characters, %0d of them flagged as budget stops.",
                 n_chars, n_stops);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cse_pkg.sv
rtl/cse_fifo.sv
rtl/cse_front.sv
rtl/cse_back.sv
rtl/cigar_string_encoder.sv
rtl/cse_checker.sv
verif/testbench.sv
